[sv/clrs_pkg.sv]
// shared constants, types and helpers for the colour label region statistics block
package clrs_pkg;

    localparam int MAX_COMPONENTS_DEF = 256;
    localparam int MAX_ROWS_DEF       = 2048;
    localparam int MAX_COLS_DEF       = 2048;

    localparam int COORD_W    = 11;
    localparam int KEY_W      = 24;
    localparam int ID_W       = 8;
    localparam int COUNT_W    = 23;
    localparam int QDEPTH     = 2;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 23'd4194304;

    typedef struct packed {
        logic               background;
        logic               overflow;
        logic               is_new;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } clrs_cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] rightmost_row;
        logic [COORD_W-1:0] centre_col;
        logic [COORD_W-1:0] centre_row;
        logic [COORD_W-1:0] max_col;
        logic [COORD_W-1:0] max_row;
        logic [COORD_W-1:0] min_col;
        logic [COORD_W-1:0] min_row;
        logic [COUNT_W-1:0] pixel_count;
        logic               table_overflow;
        logic               is_background;
        logic               is_new;
        logic [ID_W-1:0]    comp_id;
    } clrs_result_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SEARCH,
        FR_PUSH
    } clrs_front_state_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                       input logic [16:0] limit);
        logic [16:0] lm1;
        lm1 = limit - 17'd1;
        if ({6'd0, v} >= limit)
            return lm1[COORD_W-1:0];
        return v;
    endfunction

endpackage

[sv/clrs_front.sv]
// front part: key table search and component numbering
module clrs_front #(
    parameter int MAX_COMPONENTS = clrs_pkg::MAX_COMPONENTS_DEF,
    parameter int MAX_ROWS       = clrs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS       = clrs_pkg::MAX_COLS_DEF,
    parameter int IDX_W          = $clog2(MAX_COMPONENTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          skip_background,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          frame_start,
    input  logic [clrs_pkg::COORD_W-1:0]  pixel_row,
    input  logic [clrs_pkg::COORD_W-1:0]  pixel_col,
    input  logic [clrs_pkg::KEY_W-1:0]    colour_key,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output clrs_pkg::clrs_cmd_t           cmd,
    output logic [IDX_W-1:0]              cmd_id
);

    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_COMPONENTS);
    localparam logic [16:0] ROW_LIM = 17'(MAX_ROWS);
    localparam logic [16:0] COL_LIM = 17'(MAX_COLS);

    logic [clrs_pkg::KEY_W-1:0] key_mem [MAX_COMPONENTS];

    clrs_pkg::clrs_front_state_t state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [clrs_pkg::KEY_W-1:0]  rd_key_reg;
    logic [clrs_pkg::KEY_W-1:0]  key_reg;
    logic [clrs_pkg::KEY_W-1:0]  wr_key;
    logic [clrs_pkg::COORD_W-1:0] row_reg, col_reg;
    clrs_pkg::clrs_cmd_t         cmd_reg, cmd_next;
    logic [IDX_W-1:0]            id_reg, id_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic                        key_we;
    logic [IDX_W-1:0]            rd_addr;
    logic [CNT_W-1:0]            idx_ext;
    logic [CNT_W-1:0]            base_count;
    logic                        accept;

    assign accept  = in_valid && in_ready;
    assign idx_ext = {1'b0, idx_reg};
    assign base_count = frame_start ? '0 : count_reg;
    // first write of a frame uses the incoming key
    assign wr_key = (state_reg == clrs_pkg::FR_IDLE) ? colour_key : key_reg;

    // search reads one entry a cycle
    always_comb
    begin
        rd_addr = idx_reg;
        if (state_reg == clrs_pkg::FR_SEARCH && rd_valid_reg)
            rd_addr = idx_reg + IDX_W'(1);
        if (state_reg == clrs_pkg::FR_IDLE)
            rd_addr = '0;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[id_next] <= wr_key;
        rd_key_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= colour_key;
            row_reg <= clrs_pkg::clamp_coord(pixel_row, ROW_LIM);
            col_reg <= clrs_pkg::clamp_coord(pixel_col, COL_LIM);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            clrs_pkg::FR_IDLE:
            begin
                if (accept)
                begin
                    if ((skip_background && colour_key == '0) || base_count == '0)
                        state_next = clrs_pkg::FR_PUSH;
                    else
                        state_next = clrs_pkg::FR_SEARCH;
                end
            end
            clrs_pkg::FR_SEARCH:
            begin
                if (rd_valid_reg && (rd_key_reg == key_reg || idx_ext + 1'b1 >= count_reg))
                    state_next = clrs_pkg::FR_PUSH;
            end
            clrs_pkg::FR_PUSH:
            begin
                if (cmd_ready)
                    state_next = clrs_pkg::FR_IDLE;
            end
            default: state_next = clrs_pkg::FR_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        count_next    = count_reg;
        idx_next      = idx_reg;
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        rd_valid_next = 1'b0;
        key_we        = 1'b0;
        in_ready      = 1'b0;
        cmd_valid     = 1'b0;
        case (state_reg)
            clrs_pkg::FR_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    count_next = base_count;
                    idx_next   = '0;
                    id_next    = '0;
                    cmd_next.row = clrs_pkg::clamp_coord(pixel_row, ROW_LIM);
                    cmd_next.col = clrs_pkg::clamp_coord(pixel_col, COL_LIM);
                    cmd_next.background = skip_background && colour_key == '0;
                    cmd_next.overflow   = 1'b0;
                    cmd_next.is_new     = 1'b0;
                    rd_valid_next = 1'b1;
                    if (!(skip_background && colour_key == '0) && base_count == '0)
                    begin
                        cmd_next.is_new = 1'b1;
                        count_next      = CNT_W'(1);
                    end
                end
            end
            clrs_pkg::FR_SEARCH:
            begin
                rd_valid_next = 1'b1;
                if (rd_valid_reg)
                begin
                    if (rd_key_reg == key_reg)
                        id_next = idx_reg;
                    else if (idx_ext + 1'b1 >= count_reg)
                    begin
                        if (count_reg >= FULL)
                            cmd_next.overflow = 1'b1;
                        else
                        begin
                            id_next         = count_reg[IDX_W-1:0];
                            cmd_next.is_new = 1'b1;
                            count_next      = count_reg + 1'b1;
                            key_we          = 1'b1;
                        end
                    end
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            clrs_pkg::FR_PUSH:
            begin
                cmd_valid = 1'b1;
            end
            default: ;
        endcase
        if (state_reg == clrs_pkg::FR_IDLE && accept && cmd_next.is_new)
            key_we = 1'b1;
    end

    assign cmd    = cmd_reg;
    assign cmd_id = id_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= clrs_pkg::FR_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        id_reg  <= id_next;
    end

endmodule

[sv/clrs_back.sv]
// back part: statistics read-modify-write and result register
module clrs_back #(
    parameter int MAX_COMPONENTS = clrs_pkg::MAX_COMPONENTS_DEF,
    parameter int IDX_W          = $clog2(MAX_COMPONENTS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cmd_valid,
    output logic                    cmd_ready,
    input  clrs_pkg::clrs_cmd_t     cmd,
    input  logic [IDX_W-1:0]        cmd_id,
    output logic                    res_valid,
    input  logic                    res_ready,
    output clrs_pkg::clrs_result_t  res
);

    localparam int CW = clrs_pkg::COORD_W;

    typedef struct packed {
        logic [clrs_pkg::COUNT_W-1:0] cnt;
        logic [CW-1:0] min_row, min_col, max_row, max_col, cen_row, cen_col, right_row;
    } stat_t;

    stat_t stat_mem [MAX_COMPONENTS];
    stat_t rd_reg, upd;
    clrs_pkg::clrs_cmd_t cmd_reg;
    logic [IDX_W-1:0] id_reg;
    logic busy_reg, busy_next;
    logic out_valid_reg, out_valid_next;
    clrs_pkg::clrs_result_t res_reg, res_next;
    logic [CW:0] sum_r, sum_c;
    logic take;

    assign take      = cmd_valid && cmd_ready;
    assign cmd_ready = !busy_reg && (!out_valid_reg || res_ready);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_reg  <= stat_mem[cmd_id];
            cmd_reg <= cmd;
            id_reg  <= cmd_id;
        end
        if (busy_reg && !cmd_reg.background && !cmd_reg.overflow)
            stat_mem[id_reg] <= upd;
    end

    always_comb
    begin
        sum_r = {1'b0, rd_reg.cen_row} + {1'b0, cmd_reg.row};
        sum_c = {1'b0, rd_reg.cen_col} + {1'b0, cmd_reg.col};
        upd = rd_reg;
        if (cmd_reg.is_new)
        begin
            upd.cnt = clrs_pkg::COUNT_W'(1);
            upd.min_row = cmd_reg.row; upd.max_row = cmd_reg.row;
            upd.cen_row = cmd_reg.row; upd.right_row = cmd_reg.row;
            upd.min_col = cmd_reg.col; upd.max_col = cmd_reg.col;
            upd.cen_col = cmd_reg.col;
        end
        else
        begin
            if (rd_reg.cnt < clrs_pkg::COUNT_LIMIT)
                upd.cnt = rd_reg.cnt + 1'b1;
            upd.cen_row = sum_r[CW:1];
            upd.cen_col = sum_c[CW:1];
            if (cmd_reg.col > rd_reg.max_col)
            begin
                upd.right_row = cmd_reg.row;
                upd.max_col   = cmd_reg.col;
            end
            if (cmd_reg.row < rd_reg.min_row) upd.min_row = cmd_reg.row;
            if (cmd_reg.col < rd_reg.min_col) upd.min_col = cmd_reg.col;
            if (cmd_reg.row > rd_reg.max_row) upd.max_row = cmd_reg.row;
        end
    end

    always_comb
    begin
        busy_next      = take;
        out_valid_next = out_valid_reg && !res_ready;
        res_next       = res_reg;
        if (busy_reg)
        begin
            out_valid_next = 1'b1;
            res_next = '0;
            res_next.is_background  = cmd_reg.background;
            res_next.table_overflow = cmd_reg.overflow;
            if (!cmd_reg.background && !cmd_reg.overflow)
            begin
                res_next.comp_id       = clrs_pkg::ID_W'(id_reg);
                res_next.is_new        = cmd_reg.is_new;
                res_next.pixel_count   = upd.cnt;
                res_next.min_row       = upd.min_row;
                res_next.min_col       = upd.min_col;
                res_next.max_row       = upd.max_row;
                res_next.max_col       = upd.max_col;
                res_next.centre_row    = upd.cen_row;
                res_next.centre_col    = upd.cen_col;
                res_next.rightmost_row = upd.right_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

[sv/colour_label_region_statistics_top.sv]
// top level of the colour label region statistics block
// usage:
//   s_axis carries one pixel item: tdata holds pixel_row, pixel_col, colour_key
//   from bit 0 up; tuser holds frame_start. m_axis carries one result item per
//   pixel with id, flags and the updated component statistics. skip_background
//   must be written through cfg_wr_en/cfg_wr_data while idle (unenforced).
// flow:
//   the front searches the key table one entry a cycle until the key matches
//   or the last entry is passed, and takes a new item only once the command
//   of the last one is pushed; the back reads the statistics memory when it
//   takes a command and writes the update together with the result register
//   in the next cycle. a frame start or a background pixel skips the search.
// reset:
//   clears the entry count, the skip_background register and all handshake
//   state; table contents are left as they are and unwritten entries are never used.
// stall:
//   when m_axis_tready is low the result register holds, the back stops
//   taking commands and the front then holds s_axis_tready low.
module colour_label_region_statistics_top #(
    parameter int MAX_COMPONENTS = clrs_pkg::MAX_COMPONENTS_DEF,
    parameter int MAX_ROWS       = clrs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS       = clrs_pkg::MAX_COLS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // pixel_row, pixel_col, colour_key, zero pad
    input  logic         s_axis_tuser,   // frame_start
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata    // component id, is_new, is_background,
                                         // table_overflow, pixel_count, min_row,
                                         // min_col, max_row, max_col, centre_row,
                                         // centre_col, rightmost_row, zero pad
);

    localparam int IDX_W = $clog2(MAX_COMPONENTS);

    logic                   skip_reg;
    logic                   cmd_valid, cmd_ready;
    clrs_pkg::clrs_cmd_t    cmd;
    logic [IDX_W-1:0]       cmd_id;
    clrs_pkg::clrs_result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_reg <= 1'b0;
        else if (cfg_wr_en)
            skip_reg <= cfg_wr_data;
    end

    clrs_front #(
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .IDX_W(IDX_W)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .skip_background(skip_reg),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .frame_start(s_axis_tuser),
        .pixel_row(s_axis_tdata[10:0]),
        .pixel_col(s_axis_tdata[21:11]),
        .colour_key(s_axis_tdata[45:22]),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .cmd_id(cmd_id)
    );

    clrs_back #(
        .MAX_COMPONENTS(MAX_COMPONENTS),
        .IDX_W(IDX_W)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .cmd_id(cmd_id),
        .res_valid(m_axis_tvalid),
        .res_ready(m_axis_tready),
        .res(res)
    );

    assign m_axis_tdata = {1'b0, res};

endmodule

[sv/clrs_checker.sv]
// port level checks for the colour label region statistics block
module clrs_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_bg_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[7:0] == 8'd0 && !m_axis_tdata[8])
        else $error("background result carries id");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
        else $error("background and overflow together");

    a_one_in: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two items accepted back to back");

endmodule

bind colour_label_region_statistics_top clrs_checker u_clrs_checker (
    .clk(clk),
    .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

[bench/colour_label_region_statistics_checker.sv]
// checker for the colour label region statistics block: predicts and compares results
module colour_label_region_statistics_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [111:0] m_axis_tdata,
    output int           errors,
    output int           pending,
    output int           results_seen,
    output int           overflow_seen,
    output int           background_seen
);

    localparam int NCOMP = clrs_pkg::MAX_COMPONENTS_DEF;
    localparam int RW    = $bits(clrs_pkg::clrs_result_t);

    logic                         skip_bg;
    int                           n_entries;
    logic [clrs_pkg::KEY_W-1:0]   comp_key   [NCOMP];
    logic [clrs_pkg::COUNT_W-1:0] comp_count [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_rmin  [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_cmin  [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_rmax  [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_cmax  [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_rctr  [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_cctr  [NCOMP];
    logic [clrs_pkg::COORD_W-1:0] comp_rright[NCOMP];
    clrs_pkg::clrs_result_t       expected_stats[$];

    function automatic clrs_pkg::clrs_result_t update_component(
        input logic fs,
        input logic [clrs_pkg::COORD_W-1:0] row,
        input logic [clrs_pkg::COORD_W-1:0] col,
        input logic [clrs_pkg::KEY_W-1:0] key);
        clrs_pkg::clrs_result_t r;
        int id;
        logic [clrs_pkg::COORD_W:0] sum;
        r = '0;
        id = -1;
        if (fs)
            n_entries = 0;
        if (skip_bg && key == '0)
        begin
            r.is_background = 1'b1;
            return r;
        end
        for (int i = 0; i < n_entries; i++)
            if (id < 0 && comp_key[i] == key)
                id = i;
        if (id < 0)
        begin
            if (n_entries >= NCOMP)
            begin
                r.table_overflow = 1'b1;
                return r;
            end
            id = n_entries;
            n_entries++;
            comp_key[id]    = key;
            comp_count[id]  = clrs_pkg::COUNT_W'(1);
            comp_rmin[id]   = row;
            comp_rmax[id]   = row;
            comp_rctr[id]   = row;
            comp_rright[id] = row;
            comp_cmin[id]   = col;
            comp_cmax[id]   = col;
            comp_cctr[id]   = col;
            r.is_new = 1'b1;
        end
        else
        begin
            if (comp_count[id] < clrs_pkg::COUNT_LIMIT)
                comp_count[id]++;
            sum = comp_rctr[id] + row;
            comp_rctr[id] = sum[clrs_pkg::COORD_W:1];
            sum = comp_cctr[id] + col;
            comp_cctr[id] = sum[clrs_pkg::COORD_W:1];
            if (col > comp_cmax[id])
            begin
                comp_rright[id] = row;
                comp_cmax[id] = col;
            end
            if (row < comp_rmin[id]) comp_rmin[id] = row;
            if (col < comp_cmin[id]) comp_cmin[id] = col;
            if (row > comp_rmax[id]) comp_rmax[id] = row;
        end
        r.comp_id       = id[clrs_pkg::ID_W-1:0];
        r.pixel_count   = comp_count[id];
        r.min_row       = comp_rmin[id];
        r.min_col       = comp_cmin[id];
        r.max_row       = comp_rmax[id];
        r.max_col       = comp_cmax[id];
        r.centre_row    = comp_rctr[id];
        r.centre_col    = comp_cctr[id];
        r.rightmost_row = comp_rright[id];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        clrs_pkg::clrs_result_t exp_r;
        clrs_pkg::clrs_result_t got;
        clrs_pkg::clrs_result_t pred;
        if (!rst_n)
        begin
            skip_bg = 1'b0;
            n_entries = 0;
            errors = 0;
            pending = 0;
            results_seen = 0;
            overflow_seen = 0;
            background_seen = 0;
            expected_stats.delete();
        end
        else
        begin
            if (cfg_wr_en)
                skip_bg = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = update_component(s_axis_tuser, s_axis_tdata[10:0],
                                        s_axis_tdata[21:11], s_axis_tdata[45:22]);
                expected_stats = {expected_stats, pred};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = clrs_pkg::clrs_result_t'(m_axis_tdata[RW-1:0]);
                results_seen++;
                if (got.table_overflow) overflow_seen++;
                if (got.is_background) background_seen++;
                if (expected_stats.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result item %h", got);
                end
                else
                begin
                    exp_r = expected_stats.pop_front();
                    if (got !== exp_r || m_axis_tdata[111:RW] !== '0)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch at result %0d", results_seen);
                            $display("  id exp %0d got %0d, new %b/%b, bg %b/%b, ovf %b/%b",
                                     exp_r.comp_id, got.comp_id, exp_r.is_new,
                                     got.is_new, exp_r.is_background, got.is_background,
                                     exp_r.table_overflow, got.table_overflow);
                            $display("  count %0d/%0d box %0d %0d %0d %0d / %0d %0d %0d %0d",
                                     exp_r.pixel_count, got.pixel_count, exp_r.min_row,
                                     exp_r.min_col, exp_r.max_row, exp_r.max_col,
                                     got.min_row, got.min_col, got.max_row, got.max_col);
                            $display("  centre %0d %0d / %0d %0d rightmost %0d / %0d",
                                     exp_r.centre_row, exp_r.centre_col, got.centre_row,
                                     got.centre_col, exp_r.rightmost_row, got.rightmost_row);
                        end
                    end
                end
            end
            pending = expected_stats.size();
        end
    end

endmodule

[bench/colour_label_region_statistics_top_tb.sv]
// testbench top for the colour label region statistics block: stimulus and verdict
module colour_label_region_statistics_top_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 300;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic         cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [111:0] m_axis_tdata;

    int  errors;
    int  pending;
    int  results_seen;
    int  overflow_seen;
    int  background_seen;
    int  cycles;
    int  pixels_sent;
    bit  sender_gaps;
    bit  calm;
    bit  hold_request;

    colour_label_region_statistics_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    colour_label_region_statistics_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .errors          (errors),
        .pending         (pending),
        .results_seen    (results_seen),
        .overflow_seen   (overflow_seen),
        .background_seen (background_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_axis_tready = 1'b0;
                for (int c = 0; c < 600; c++)
                    @(negedge clk);
                hold_request = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 9);
                m_axis_tready = 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic send_pixel(input logic fs, input logic [10:0] row,
                              input logic [10:0] col, input logic [23:0] key);
        int n;
        if (sender_gaps && !calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 9);
            s_axis_tvalid = 1'b0;
            repeat (n) @(negedge clk);
        end
        s_axis_tuser  = fs;
        s_axis_tdata  = {2'b00, key, col, row};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_skip(input logic v);
        wait_idle();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // one frame drawn from a small palette, coordinates walking or random
    task automatic send_frame(input int len, input int colours);
        logic [23:0] palette[16];
        logic [10:0] row;
        logic [10:0] col;
        for (int i = 0; i < colours; i++)
            palette[i] = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom);
        row = 11'($urandom);
        col = 11'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                row = 11'($urandom);
                col = 11'($urandom);
            end
            else
            begin
                col = col + 11'($urandom_range(0, 3));
                row = row + 11'($urandom_range(0, 1));
            end
            send_pixel(i == 0, row, col, palette[$urandom_range(0, colours - 1)]);
        end
    endtask

    initial
    begin
        int phase;
        cycles        = 0;
        pixels_sent   = 0;
        sender_gaps   = 1'b1;
        calm          = 1'b0;
        hold_request  = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, black as a colour, then as background
        write_skip(1'b0);
        send_pixel(1'b1, 11'd0,    11'd0,    24'h000000);
        send_pixel(1'b0, 11'd2047, 11'd2047, 24'h000000);
        send_pixel(1'b0, 11'd0,    11'd2047, 24'hFFFFFF);
        send_pixel(1'b0, 11'd2047, 11'd0,    24'hFFFFFF);
        send_pixel(1'b0, 11'd1024, 11'd2047, 24'hFFFFFF);
        send_pixel(1'b0, 11'd5,    11'd3,    24'hAAAAAA);
        send_pixel(1'b0, 11'd7,    11'd3,    24'h555555);
        send_pixel(1'b0, 11'd6,    11'd4,    24'hAAAAAA);
        write_skip(1'b1);
        send_pixel(1'b0, 11'd10,   11'd10,   24'h000000);
        send_pixel(1'b0, 11'd11,   11'd12,   24'hFFFFFF);
        send_pixel(1'b1, 11'd2047, 11'd2047, 24'h000000);
        send_pixel(1'b0, 11'd1,    11'd1,    24'hFFFFFF);
        send_pixel(1'b0, 11'd2,    11'd2,    24'h000001);
        send_pixel(1'b1, 11'd3,    11'd3,    24'h800000);

        // table overflow: more distinct colours than the table holds
        write_skip(1'b0);
        for (int i = 0; i < 262; i++)
            send_pixel(i == 0, 11'($urandom), 11'($urandom), 24'(i * 7919 + 1));
        send_pixel(1'b0, 11'd9, 11'd9, 24'd1);
        send_pixel(1'b1, 11'd9, 11'd9, 24'd0);

        // random frames, the register switching between phases
        for (phase = 0; phase < 6; phase++)
        begin
            write_skip(phase[0]);
            if (phase == 5)
                calm = 1'b1;
            for (int f = 0; f < 8; f++)
            begin
                if (phase == 2 && f == 3)
                    hold_request = 1'b1;
                if (phase == 3 && f == 4)
                    wait_idle();
                if ($urandom_range(0, 9) == 0)
                    send_pixel(1'($urandom_range(0, 1)), 11'($urandom), 11'($urandom),
                               24'($urandom));
                else
                    send_frame($urandom_range(12, 36), $urandom_range(1, 16));
            end
        end

        s_axis_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("sent %0d pixels, %0d results checked", pixels_sent, results_seen);
        $display("%0d table overflow and %0d background results seen",
                 overflow_seen, background_seen);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
sv/clrs_pkg.sv
sv/clrs_front.sv
sv/clrs_back.sv
sv/colour_label_region_statistics_top.sv
sv/clrs_checker.sv
bench/colour_label_region_statistics_checker.sv
bench/colour_label_region_statistics_top_tb.sv
